>>> rtl/wcl_pkg.sv
`default_nettype none

package wcl_pkg;

	// elaboration defaults
	localparam int CHANNELS_DEF   = 2;
	localparam int TIME_WIDTH_DEF = 32;

	// register reset values
	localparam logic [31:0] REFILL_INTERVAL_RST = 32'd1000;
	localparam logic [15:0] MAX_BALANCE_RST     = 16'd255;

	// stream payload widths
	localparam int IN_TDATA_W  = 40;
	localparam int IN_TUSER_W  = 3;
	localparam int OUT_TDATA_W = 24;

	// configuration register indexes
	localparam logic [0:0] REG_REFILL_INTERVAL = 1'b0;
	localparam logic [0:0] REG_MAX_BALANCE     = 1'b1;

	typedef enum logic [1:0] {
		OP_INIT    = 2'd0,
		OP_REQUEST = 2'd1,
		OP_CONSUME = 2'd2
	} opcode_t;

endpackage

`default_nettype wire

>>> rtl/watering_credit_limiter.sv
// per-channel token bucket credit limiter
//
// input stream: one transfer is one command (init, request or consume) for a
// channel account. output stream: exactly one result transfer per command,
// carrying the granted units and the channel balance after the command.
// configuration: cfg_we writes refill_interval (index 0) or max_balance
// (index 1); write only while no command is in flight.
//
// an accepted command passes through ST_PREP and ends in ST_DONE; init,
// consume and the unused opcode go straight from one to the other, while
// a request first runs ST_DIV, the serial restoring divider that works
// out one quotient bit per cycle while dividing the elapsed ticks by the
// refill interval, and then ST_FIN. one command at a time: s_tready
// returns at the edge that loads the result into the output register.
//
// reset: every balance goes to 255, the refill times and remainders to
// zero, the registers to their reset values, no result pending.
// stall: the result waits in the output register until m_tready; a new
// command is taken meanwhile, but its result holds until the slot frees.
`default_nettype none

module watering_credit_limiter
	import wcl_pkg::*;
#(
	parameter int CHANNELS   = CHANNELS_DEF,
	parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    s_tvalid,
	output logic                   s_tready,
	input  wire [IN_TDATA_W-1:0]   s_tdata,   // now[31:0], amount[39:32]
	input  wire [IN_TUSER_W-1:0]   s_tuser,   // opcode[1:0], channel[2]
	output logic                   m_tvalid,
	input  wire                    m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,   // granted[7:0], balance_after[23:8]
	input  wire                    cfg_we,
	input  wire [0:0]              cfg_index,
	input  wire [31:0]             cfg_data
);

	localparam int TW      = TIME_WIDTH;
	localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int CNT_W   = $clog2(TIME_WIDTH);
	// partial remainder stays below twice the 32-bit divisor
	localparam int RW      = 33;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_DIV,
		ST_FIN,
		ST_DONE
	} state_t;

	state_t state_q;

	// configuration
	logic [31:0] refill_interval_q;
	logic [15:0] max_balance_q;

	// channel accounts
	logic [15:0]   credit_q    [CHANNELS];
	logic [TW-1:0] last_time_q [CHANNELS];
	logic [TW-1:0] tick_rem_q  [CHANNELS];

	// latched command
	logic [1:0]  op_q;
	logic        ch_q;
	logic [31:0] now_q;
	logic [7:0]  amount_q;

	// divider
	logic [TW-1:0]    dvd_q;   // dividend, shifts out as quotient shifts in
	logic [RW-1:0]    rem_q;
	logic [CNT_W-1:0] cnt_q;

	// pending result and output register
	logic [7:0]             res_grant_q;
	logic [15:0]            res_bal_q;
	logic                   m_tvalid_q;
	logic [OUT_TDATA_W-1:0] m_tdata_q;

	logic                ch_ok;
	logic [CH_IDX_W-1:0] ch_idx;
	logic [15:0]         bal_cur;
	logic [TW-1:0]       now_t;
	logic [TW-1:0]       dt;
	logic [31:0]         intv_eff;
	logic [RW-1:0]       trial;
	logic                trial_ge;
	logic [15:0]         bal_refill;
	logic [16:0]         sum17;
	logic [15:0]         bal_consume;
	logic [7:0]          grant_req;
	logic                out_load;

	assign ch_ok   = (int'(ch_q) < CHANNELS);
	assign ch_idx  = ch_ok ? CH_IDX_W'(ch_q) : '0;
	assign bal_cur = credit_q[ch_idx];
	assign now_t   = TW'(now_q);

	// elapsed ticks plus carried remainder, modular in the timer width
	assign dt = now_t - last_time_q[ch_idx] + tick_rem_q[ch_idx];

	// a zero interval acts as one
	assign intv_eff = (refill_interval_q == 32'd0) ? 32'd1 : refill_interval_q;

	assign trial    = {rem_q[RW-2:0], dvd_q[TW-1]};
	assign trial_ge = (trial >= {1'b0, intv_eff});

	// refill with saturation at the cap; quotient lives in dvd_q
	assign sum17 = {1'b0, dvd_q[15:0]} + {1'b0, bal_cur};
	always_comb begin
		if (dvd_q >= TW'(max_balance_q)) begin
			bal_refill = max_balance_q;
		end else if (sum17 < {1'b0, max_balance_q}) begin
			bal_refill = sum17[15:0];
		end else begin
			bal_refill = max_balance_q;
		end
	end

	assign grant_req   = ({8'd0, amount_q} < bal_refill) ? amount_q : bal_refill[7:0];
	assign bal_consume = ({8'd0, amount_q} < bal_cur) ? (bal_cur - {8'd0, amount_q}) : 16'd0;

	// finished result moves into a free or freeing output slot
	assign out_load = (state_q == ST_DONE) && (!m_tvalid_q || m_tready);

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q           <= ST_IDLE;
			m_tvalid_q        <= 1'b0;
			refill_interval_q <= REFILL_INTERVAL_RST;
			max_balance_q     <= MAX_BALANCE_RST;
			for (int i = 0; i < CHANNELS; i++) begin
				credit_q[i]    <= MAX_BALANCE_RST;
				last_time_q[i] <= '0;
				tick_rem_q[i]  <= '0;
			end
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_REFILL_INTERVAL: refill_interval_q <= cfg_data;
					REG_MAX_BALANCE:     max_balance_q     <= cfg_data[15:0];
					default: ;
				endcase
			end

			// output register: load a finished result, or clear once taken
			if (out_load) begin
				m_tvalid_q <= 1'b1;
				m_tdata_q  <= {res_bal_q, res_grant_q};
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						op_q     <= s_tuser[1:0];
						ch_q     <= s_tuser[2];
						now_q    <= s_tdata[31:0];
						amount_q <= s_tdata[39:32];
						state_q  <= ST_PREP;
					end
				end
				ST_PREP: begin
					res_grant_q <= 8'd0;
					state_q     <= (ch_ok && op_q == OP_REQUEST) ? ST_DIV : ST_DONE;
					if (!ch_ok) begin
						// channel without an account: zero result, no update
						res_bal_q <= 16'd0;
					end else begin
						case (op_q)
							OP_INIT: begin
								credit_q[ch_idx]    <= max_balance_q;
								tick_rem_q[ch_idx]  <= '0;
								last_time_q[ch_idx] <= now_t;
								res_bal_q           <= max_balance_q;
							end
							OP_REQUEST: begin
								dvd_q <= dt;
								rem_q <= '0;
								cnt_q <= '0;
							end
							OP_CONSUME: begin
								credit_q[ch_idx] <= bal_consume;
								res_bal_q        <= bal_consume;
							end
							default: begin
								res_bal_q <= bal_cur;
							end
						endcase
					end
				end
				ST_DIV: begin
					// one restoring step per cycle
					rem_q <= trial_ge ? (trial - {1'b0, intv_eff}) : trial;
					dvd_q <= {dvd_q[TW-2:0], trial_ge};
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(TIME_WIDTH - 1)) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					credit_q[ch_idx]    <= bal_refill;
					tick_rem_q[ch_idx]  <= TW'(rem_q);
					last_time_q[ch_idx] <= now_t;
					res_bal_q           <= bal_refill;
					res_grant_q         <= grant_req;
					state_q             <= ST_DONE;
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

>>> rtl/wcl_checker.sv
`default_nettype none

module wcl_checker
	import wcl_pkg::*;
(
	input wire                   clk,
	input wire                   arst_n,
	input wire                   s_tvalid,
	input wire                   s_tready,
	input wire [IN_TDATA_W-1:0]  s_tdata,
	input wire [IN_TUSER_W-1:0]  s_tuser,
	input wire                   m_tvalid,
	input wire                   m_tready,
	input wire [OUT_TDATA_W-1:0] m_tdata,
	input wire                   cfg_we,
	input wire [0:0]             cfg_index,
	input wire [31:0]            cfg_data
);

	// one command in flight: input closes right after a transfer
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input still ready after a transfer");

	// a new result only appears while a command is being worked on
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(!s_tready))
		else $error("result appeared with no command in flight");

	// a grant never exceeds the balance left
	a_grant_le_balance: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ({8'd0, m_tdata[7:0]} <= m_tdata[23:8]))
		else $error("grant larger than balance");

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result changed");

endmodule

bind watering_credit_limiter wcl_checker u_wcl_checker (.*);

`default_nettype wire

>>> tb/tb_watering_credit_limiter.sv
`default_nettype none

module tb_watering_credit_limiter;
	import wcl_pkg::*;

	// bench timing
	localparam int CLK_HALF       = 10;
	localparam int RESET_CYCLES   = 5;
	// settle time, rounded up from a request's run through the divider
	localparam int SETTLE_CYCLES  = 40;
	// cycles with no transfer on either stream before the run is abandoned
	localparam int WATCHDOG_LIMIT = 2000;
	// percent of cycles in which a side holds off
	localparam int IDLE_PCT       = 18;
	localparam int MAX_REPORTS    = 10;

	// opcode value the block does not define, kept next to the package codes
	localparam logic [1:0] OP_UNUSED = 2'd3;

	// one result transfer as it sits in m_tdata: granted low, balance high
	typedef struct packed {
		logic [15:0] balance;
		logic [7:0]  granted;
	} credit_result_t;

	// dut ports, all inputs known from time zero
	logic                   clk       = 1'b0;
	logic                   arst_n    = 1'b0;
	logic                   s_tvalid  = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata   = '0;  // now[31:0], amount[39:32]
	logic [IN_TUSER_W-1:0]  s_tuser   = '0;  // opcode[1:0], channel[2]
	logic                   m_tvalid;
	logic                   m_tready  = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;         // granted[7:0], balance_after[23:8]
	logic                   cfg_we    = 1'b0;
	logic [0:0]             cfg_index = '0;
	logic [31:0]            cfg_data  = '0;

	// shadow copy of the per-channel accounts and the two registers
	logic [31:0] acct_balance [2];
	logic [31:0] acct_last    [2];
	logic [31:0] acct_rem     [2];
	logic [31:0] reg_interval;
	logic [15:0] reg_cap;

	// results predicted for accepted commands, oldest first
	credit_result_t pending_results [$];

	int          mismatch_count = 0;
	int          stall_cycles   = 0;
	// hold-off switches for the source and the sink
	bit          src_idle_on    = 1'b1;
	bit          sink_idle_on   = 1'b1;
	// free-running timer value the random traffic walks forward
	logic [31:0] tick_now       = '0;

	watering_credit_limiter dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #CLK_HALF clk = ~clk;

	// accounts and registers as they come out of reset
	task automatic reset_accounts();
		reg_interval = REFILL_INTERVAL_RST;
		reg_cap      = MAX_BALANCE_RST;
		for (int i = 0; i < 2; i++) begin
			acct_balance[i] = 32'd255;
			acct_last[i]    = '0;
			acct_rem[i]     = '0;
		end
	endtask

	// apply one accepted command to the shadow accounts, queue its result
	task automatic credit_predict(input logic [1:0] op, input logic ch,
			input logic [31:0] stamp, input logic [7:0] amt);
		logic [31:0]    ivl;
		logic [31:0]    dt;
		logic [31:0]    earned;
		logic [31:0]    sum;
		logic [31:0]    cap;
		credit_result_t res;
		cap = {16'd0, reg_cap};
		res.granted = 8'd0;
		case (op)
			OP_INIT: begin
				acct_balance[ch] = cap;
				acct_rem[ch]     = '0;
				acct_last[ch]    = stamp;
			end
			OP_REQUEST: begin
				// zero interval counts as one tick per unit
				ivl = (reg_interval == 32'd0) ? 32'd1 : reg_interval;
				// elapsed ticks wrap modulo the timer width
				dt = stamp - acct_last[ch] + acct_rem[ch];
				earned = dt / ivl;
				if (earned >= cap)
					sum = cap;
				else
					sum = earned + acct_balance[ch];
				// a balance left above a lowered cap is clamped here
				acct_balance[ch] = (sum < cap) ? sum : cap;
				acct_rem[ch]     = dt % ivl;
				acct_last[ch]    = stamp;
				res.granted = ({24'd0, amt} < acct_balance[ch]) ? amt
					: acct_balance[ch][7:0];
			end
			OP_CONSUME: begin
				// floor at zero, no clamp to the cap
				acct_balance[ch] = ({24'd0, amt} < acct_balance[ch])
					? acct_balance[ch] - {24'd0, amt} : 32'd0;
			end
			default: begin
				// unused opcode leaves the account alone
			end
		endcase
		res.balance = acct_balance[ch][15:0];
		pending_results.push_back(res);
	endtask

	// offer one command, with a random hold-off first, and wait for its transfer
	task automatic send_command(input logic [1:0] op, input logic ch,
			input logic [31:0] stamp, input logic [7:0] amt);
		if (src_idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
			s_tvalid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(0, 99) < IDLE_PCT);
		end
		// valid stays high across back-to-back commands
		s_tvalid <= 1'b1;
		s_tdata  <= {amt, stamp};
		s_tuser  <= {ch, op};
		do
			@(posedge clk);
		while (!s_tready);
		credit_predict(op, ch, stamp, amt);
	endtask

	// let every predicted result come back, then give the block time to settle
	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// write both registers on consecutive edges, only while the block is idle
	task automatic configure(input logic [31:0] interval, input logic [15:0] cap);
		cfg_we    <= 1'b1;
		cfg_index <= REG_REFILL_INTERVAL;
		cfg_data  <= interval;
		@(posedge clk);
		reg_interval = interval;
		cfg_index <= REG_MAX_BALANCE;
		cfg_data  <= {16'd0, cap};
		@(posedge clk);
		reg_cap = cap;
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic note_mismatch(input string what, input credit_result_t want,
			input credit_result_t got);
		mismatch_count++;
		if (mismatch_count <= MAX_REPORTS)
			$display("mismatch %0d (%s): exp granted=%0d balance=%0d, got granted=%0d balance=%0d",
				mismatch_count, what, want.granted, want.balance, got.granted,
				got.balance);
	endtask

	// result side: check each transfer against the oldest prediction, drive tready
	always @(posedge clk) begin : result_check
		credit_result_t want;
		credit_result_t got;
		got = m_tdata;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				note_mismatch("result with no command pending", '0, got);
			end else begin
				want = pending_results.pop_front();
				if (got.granted != want.granted)
					note_mismatch("granted", want, got);
				else if (got.balance != want.balance)
					note_mismatch("balance_after", want, got);
			end
		end
		if (sink_idle_on)
			m_tready <= ($urandom_range(0, 99) >= IDLE_PCT);
		else
			m_tready <= 1'b1;
	end

	// watchdog: too long without any transfer means the block is stuck
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles + 1 >= WATCHDOG_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	// reset accounts, refill with remainder carry, floor at zero, unused opcode
	task automatic test_reset_state();
		send_command(OP_REQUEST, 1'b0, 32'd0, 8'd255);
		// one unit earned, 999 ticks carried
		send_command(OP_REQUEST, 1'b1, 32'd1999, 8'd7);
		send_command(OP_CONSUME, 1'b1, 32'd0, 8'd255);
		send_command(OP_CONSUME, 1'b1, 32'd0, 8'd1);
		// carried remainder completes the next unit
		send_command(OP_REQUEST, 1'b1, 32'd2001, 8'd255);
		send_command(OP_UNUSED, 1'b1, 32'd0, 8'd0);
		send_command(OP_UNUSED, 1'b0, 32'hFFFF_FFFF, 8'd255);
		send_command(OP_INIT, 1'b0, 32'hFFFF_FFF0, 8'd0);
		drain_results();
	endtask

	// interval and cap at their limits, timer wrap, zero interval
	task automatic test_register_extremes();
		configure(32'd1, 16'd0);
		// elapsed time wraps through zero, balance above the new cap drops to 0
		send_command(OP_REQUEST, 1'b0, 32'h0000_0010, 8'd255);
		send_command(OP_CONSUME, 1'b1, 32'd0, 8'd0);
		send_command(OP_INIT, 1'b1, 32'd5, 8'd0);
		drain_results();
		configure(32'd0, 16'hFFFF);
		send_command(OP_REQUEST, 1'b0, 32'h0000_0074, 8'd200);
		send_command(OP_REQUEST, 1'b1, 32'hFFFF_FFFF, 8'd255);
		send_command(OP_CONSUME, 1'b1, 32'd0, 8'd255);
		drain_results();
		configure(32'hFFFF_FFFF, 16'hFFFF);
		send_command(OP_INIT, 1'b0, 32'd0, 8'd0);
		send_command(OP_REQUEST, 1'b0, 32'hFFFF_FFFF, 8'd128);
		send_command(OP_CONSUME, 1'b0, 32'd0, 8'd255);
		send_command(OP_REQUEST, 1'b0, 32'hFFFF_FFFF, 8'd1);
		drain_results();
	endtask

	// cap lowered below earned credit: consume subtracts, request clamps
	task automatic test_balance_over_cap();
		configure(32'd7, 16'd100);
		send_command(OP_CONSUME, 1'b0, 32'd0, 8'd80);
		send_command(OP_REQUEST, 1'b0, 32'd3, 8'd255);
		send_command(OP_CONSUME, 1'b1, 32'd0, 8'd17);
		send_command(OP_REQUEST, 1'b1, 32'd40, 8'd60);
		drain_results();
	endtask

	// next timer value: mostly a few intervals on, sometimes still, a jump or a step back
	function automatic logic [31:0] advance_clock(input logic [31:0] base);
		logic [31:0] ivl;
		logic [31:0] span;
		int          pick;
		ivl  = (reg_interval == 32'd0) ? 32'd1 : reg_interval;
		span = (ivl > 32'h00FF_FFFF) ? 32'hFFFF_FFFF : ivl * 32'd6;
		pick = $urandom_range(0, 99);
		if (pick < 15)
			return base;
		else if (pick < 85)
			return base + $urandom_range(0, span);
		else if (pick < 95)
			return $urandom;
		else
			return base - $urandom_range(1, 1000);
	endfunction

	// one setting of the registers, then a run of random commands
	task automatic run_random_phase(input logic [31:0] interval, input logic [15:0] cap,
			input int count);
		logic [1:0] op;
		logic       ch;
		logic [7:0] amt;
		int         pick;
		configure(interval, cap);
		tick_now = $urandom;
		// well-formed start: both accounts initialized at the current time
		send_command(OP_INIT, 1'b0, tick_now, 8'($urandom));
		send_command(OP_INIT, 1'b1, tick_now, 8'($urandom));
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(0, 99);
			if (pick < 10)
				op = OP_INIT;
			else if (pick < 55)
				op = OP_REQUEST;
			else if (pick < 97)
				op = OP_CONSUME;
			else
				op = OP_UNUSED;
			ch = 1'($urandom);
			pick = $urandom_range(0, 99);
			if (pick < 10)
				amt = 8'd0;
			else if (pick < 20)
				amt = 8'd255;
			else
				amt = 8'($urandom_range(0, 255));
			tick_now = advance_clock(tick_now);
			send_command(op, ch, tick_now, amt);
		end
		drain_results();
	endtask

	task automatic test_random_traffic();
		run_random_phase(32'd1000, 16'd255, 200);
		run_random_phase(32'd1, 16'd0, 150);
		run_random_phase(32'd0, 16'hFFFF, 200);
		run_random_phase(32'hFFFF_FFFF, 16'hFFFF, 150);
		// full-rate stretch: neither side holds off
		src_idle_on  = 1'b0;
		sink_idle_on = 1'b0;
		run_random_phase(32'($urandom_range(1, 64)), 16'($urandom_range(0, 300)), 250);
		src_idle_on  = 1'b1;
		sink_idle_on = 1'b1;
		run_random_phase(32'd1, 16'd1, 150);
		run_random_phase($urandom, 16'($urandom_range(0, 65535)), 150);
		run_random_phase(32'($urandom_range(1, 5000)), 16'($urandom_range(0, 255)), 250);
		run_random_phase(32'($urandom_range(1, 16)), 16'hFFFF, 150);
		run_random_phase(32'd1000, 16'd255, 150);
	endtask

	initial begin
		reset_accounts();
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_state();
		test_register_extremes();
		test_balance_over_cap();
		test_random_traffic();
		drain_results();
		if (mismatch_count == 0 && pending_results.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

`default_nettype wire
